// ===== src/bwb_pkg.sv =====
// ---------------------------------------------------------------------------
// bwb_pkg
// Shared types, constants and helpers of the rolling-ball tick engine.
// ---------------------------------------------------------------------------
package bwb_pkg;

    localparam int FRAC_SCALE = 16;
    localparam int FRAC_SHIFT = 4;
    localparam int FIELD_W    = 130;
    localparam int FIELD_H    = 138;
    localparam int BALL_R     = 3;
    localparam int POS_LO     = BALL_R * FRAC_SCALE;
    localparam int POS_HI_X   = (FIELD_W - BALL_R) * FRAC_SCALE;
    localparam int POS_HI_Y   = (FIELD_H - BALL_R) * FRAC_SCALE;
    localparam int POS_MAX_X  = FIELD_W * FRAC_SCALE;
    localparam int POS_MAX_Y  = FIELD_H * FRAC_SCALE;
    localparam int NUM_BORDERS = 4;

    localparam int DIV_W   = 32;
    localparam int DIVS_W  = 20;
    localparam int DIVC_W  = $clog2(DIV_W + 1);

    typedef enum logic [1:0] {
        REQ_WALL  = 2'd0,
        REQ_PLACE = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ROLL = 2'd1,
        ST_CUP  = 2'd2,
        ST_STOP = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_CUP_X     = 3'd0,
        CFG_CUP_Y     = 3'd1,
        CFG_CUP_R     = 3'd2,
        CFG_WALL_CNT  = 3'd3,
        CFG_STOP_THR  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SEG_ISSUE, S_SEG_LOAD, S_X1, S_X2, S_X3,
        S_REF0, S_REF1, S_DIVX, S_REF2, S_DIVY, S_REF3,
        S_MOVE, S_CUP, S_FINISH
    } fsm_t;

    typedef struct packed {
        logic signed [8:0] x1;
        logic signed [8:0] y1;
        logic signed [8:0] x2;
        logic signed [8:0] y2;
    } seg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    // The four field borders, walked clockwise from the top edge.
    function automatic seg_t border_seg(input logic [1:0] idx);
        seg_t s;
        case (idx)
            2'd0:    s = '{9'sd0, 9'sd0, 9'(FIELD_W), 9'sd0};
            2'd1:    s = '{9'(FIELD_W), 9'sd0, 9'(FIELD_W), 9'(FIELD_H)};
            2'd2:    s = '{9'(FIELD_W), 9'(FIELD_H), 9'sd0, 9'(FIELD_H)};
            default: s = '{9'sd0, 9'(FIELD_H), 9'sd0, 9'sd0};
        endcase
        return s;
    endfunction

    // Fixed point to pixels, truncating toward zero.
    function automatic logic signed [9:0] to_pix(input logic signed [13:0] v);
        logic signed [13:0] t;
        t = v[13] ? v + 14'(FRAC_SCALE - 1) : v;
        return t[13:FRAC_SHIFT];
    endfunction

endpackage

// ===== src/bwb_ram.sv =====
// ---------------------------------------------------------------------------
// bwb_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module bwb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 12,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bwb_div.sv =====
// ---------------------------------------------------------------------------
// bwb_div
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bwb_div
    import bwb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic [DIVC_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIVC_W'(DIV_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits.
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = DIVS_W'(shifted - {1'b0, dvs_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVS_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIVC_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/bwb_cross.sv =====
// ---------------------------------------------------------------------------
// bwb_cross
// Two-stage segment intersection test of the ball path against one segment.
// ---------------------------------------------------------------------------
module bwb_cross
    import bwb_pkg::*;
(
    input  logic              clk,
    input  logic signed [9:0] ax,
    input  logic signed [9:0] ay,
    input  logic signed [9:0] bx,
    input  logic signed [9:0] by,
    input  seg_t              seg,
    output logic              hit
);

    logic signed [10:0] px_reg, py_reg, qx_reg, qy_reg, ex_reg, ey_reg;
    logic signed [23:0] den_reg, t_reg, u_reg;

    always_ff @(posedge clk)
    begin
        px_reg  <= 11'(bx) - 11'(ax);
        py_reg  <= 11'(by) - 11'(ay);
        qx_reg  <= 11'(seg.x2) - 11'(seg.x1);
        qy_reg  <= 11'(seg.y2) - 11'(seg.y1);
        ex_reg  <= 11'(seg.x1) - 11'(ax);
        ey_reg  <= 11'(seg.y1) - 11'(ay);
        den_reg <= 24'(px_reg * qy_reg) - 24'(py_reg * qx_reg);
        t_reg   <= 24'(ex_reg * qy_reg) - 24'(ey_reg * qx_reg);
        u_reg   <= 24'(ex_reg * py_reg) - 24'(ey_reg * px_reg);
    end

    always_comb
    begin
        if (den_reg == '0)
        begin
            hit = 1'b0;
        end
        else if (den_reg > 0)
        begin
            hit = (t_reg >= 0) && (t_reg <= den_reg) && (u_reg >= 0) && (u_reg <= den_reg);
        end
        else
        begin
            hit = (t_reg <= 0) && (t_reg >= den_reg) && (u_reg <= 0) && (u_reg >= den_reg);
        end
    end

endmodule

// ===== src/ball_wall_bounce_step_core.sv =====
// ---------------------------------------------------------------------------
// ball_wall_bounce_step_core
// Fixed-point rolling ball with wall table, reflection, friction and cup test.
// ---------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall and each gives exactly one result
// item on out_valid/out_stall. A wall write stores a segment in the wall RAM,
// a place item loads position and velocity, and a tick moves a rolling ball.
// Configuration registers are written on cfg_valid/cfg_ready (always ready);
// the user must write them only while idle; the block does not enforce this.
// Wall, place and ignored items go straight to the finish state, which places
// their result in the output register. A tick tests the segments in turn
// (the four borders, then up to wall_count walls); each wall needs a wall
// RAM read and each segment the two-stage crossing test. A reflection adds
// two 32-step divisions in the shared serial divider.
// One item is processed at a time; in_stall is high while an item is at work
// or its result cannot yet be placed in the output register.
// Reset clears ball state and loads the register defaults; the wall RAM is
// not cleared and must be written before its entries are used.
// A stalled result holds in the output register; the engine waits for it.
// ---------------------------------------------------------------------------
module ball_wall_bounce_step_core
    import bwb_pkg::*;
#(
    parameter int WALL_SLOTS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [3:0]         wall_index,
    input  logic signed [8:0]  seg_x1,
    input  logic signed [8:0]  seg_y1,
    input  logic signed [8:0]  seg_x2,
    input  logic signed [8:0]  seg_y2,
    input  logic [11:0]        start_x,
    input  logic [11:0]        start_y,
    input  logic signed [10:0] start_vx,
    input  logic signed [10:0] start_vy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [11:0]        pos_x,
    output logic [11:0]        pos_y,
    output logic signed [10:0] vel_x,
    output logic signed [10:0] vel_y,
    output logic               bounced,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int AW     = (WALL_SLOTS > 1) ? $clog2(WALL_SLOTS) : 1;
    localparam int SEG_CW = $clog2(WALL_SLOTS + NUM_BORDERS + 1);

    function automatic logic [10:0] mag11(input logic signed [11:0] v);
        logic signed [11:0] w;
        w = (v < 0) ? -v : v;
        return w[10:0];
    endfunction

    function automatic logic signed [10:0] scale78_sat(input logic signed [33:0] v);
        logic signed [37:0] p;
        logic signed [37:0] q;
        p = 38'(v) * 38'sd7;
        q = (p < 0) ? (p + 38'sd7) >>> 3 : p >>> 3;
        if (q > 38'sd1023)
        begin
            return 11'sd1023;
        end
        if (q < -38'sd1024)
        begin
            return -11'sd1024;
        end
        return q[10:0];
    endfunction

    // Configuration registers
    logic [7:0] cup_x_reg, cup_y_reg, stop_thr_reg;
    logic [3:0] cup_r_reg, wall_cnt_reg;

    // Ball state
    logic [11:0]        ball_px_reg, ball_px_next, ball_py_reg, ball_py_next;
    logic signed [10:0] ball_vx_reg, ball_vx_next, ball_vy_reg, ball_vy_next;
    logic               rolling_reg, rolling_next;

    // Sequencer
    fsm_t              state_reg, state_next;
    logic [SEG_CW-1:0] seg_cnt_reg, seg_cnt_next;
    logic [SEG_CW-1:0] seg_total;
    logic signed [9:0] ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;
    seg_t              seg_reg, seg_next;
    logic signed [10:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [19:0]       lsq_reg, lsq_next;
    logic signed [22:0] dot_reg, dot_next;
    logic              neg_reg, neg_next;
    logic signed [32:0] qx_reg, qx_next;
    status_t           stat_reg, stat_next;
    logic              bnc_reg, bnc_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    status_t            o_status_reg, o_status_next;
    logic [11:0]        o_px_reg, o_px_next, o_py_reg, o_py_next;
    logic signed [10:0] o_vx_reg, o_vx_next, o_vy_reg, o_vy_next;
    logic               o_bnc_reg, o_bnc_next;

    // Datapath
    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [35:0]        ram_rdata;
    logic               hit;
    div_req_t           div_req;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quo;
    logic signed [34:0] num;
    logic signed [33:0] prod;
    logic signed [10:0] nmul;
    logic [SEG_CW-1:0]  wall_sel;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign ram_we    = accept && (req_t'(req_type) == REQ_WALL) && (wall_index < WALL_SLOTS);
    assign wall_sel  = seg_cnt_reg - SEG_CW'(NUM_BORDERS);
    assign ram_raddr = wall_sel[AW-1:0];
    assign seg_total = SEG_CW'(NUM_BORDERS)
                     + ((wall_cnt_reg > WALL_SLOTS) ? SEG_CW'(WALL_SLOTS) : SEG_CW'(wall_cnt_reg));

    bwb_ram #(
        .WIDTH (36),
        .DEPTH (WALL_SLOTS)
    ) u_wall_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(wall_index)),
        .wdata ({seg_x1, seg_y1, seg_x2, seg_y2}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bwb_cross u_cross (
        .clk (clk),
        .ax  (ax_reg),
        .ay  (ay_reg),
        .bx  (bx_reg),
        .by  (by_reg),
        .seg (seg_reg),
        .hit (hit)
    );

    bwb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cup_x_reg    <= 8'd65;
            cup_y_reg    <= 8'd18;
            cup_r_reg    <= 4'd5;
            wall_cnt_reg <= 4'd0;
            stop_thr_reg <= 8'd6;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CUP_X:    cup_x_reg    <= cfg_data;
                CFG_CUP_Y:    cup_y_reg    <= cfg_data;
                CFG_CUP_R:    cup_r_reg    <= cfg_data[3:0];
                CFG_WALL_CNT: wall_cnt_reg <= cfg_data[3:0];
                CFG_STOP_THR: stop_thr_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_cnt_reg   <= '0;
            ball_px_reg   <= '0;
            ball_py_reg   <= '0;
            ball_vx_reg   <= '0;
            ball_vy_reg   <= '0;
            rolling_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_cnt_reg   <= seg_cnt_next;
            ball_px_reg   <= ball_px_next;
            ball_py_reg   <= ball_py_next;
            ball_vx_reg   <= ball_vx_next;
            ball_vy_reg   <= ball_vy_next;
            rolling_reg   <= rolling_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        seg_reg      <= seg_next;
        nx_reg       <= nx_next;
        ny_reg       <= ny_next;
        lsq_reg      <= lsq_next;
        dot_reg      <= dot_next;
        neg_reg      <= neg_next;
        qx_reg       <= qx_next;
        stat_reg     <= stat_next;
        bnc_reg      <= bnc_next;
        o_status_reg <= o_status_next;
        o_px_reg     <= o_px_next;
        o_py_reg     <= o_py_next;
        o_vx_reg     <= o_vx_next;
        o_vy_reg     <= o_vy_next;
        o_bnc_reg    <= o_bnc_next;
    end

    always_comb
    begin
        logic signed [13:0] sx, sy;
        logic signed [11:0] vx2, vy2;
        logic [10:0]        m;
        logic [13:0]        b78;
        logic [14:0]        f;
        logic signed [9:0]  cdx, cdy;
        logic [20:0]        dsq;
        logic [11:0]        spd;
        logic signed [32:0] qy;

        state_next     = state_reg;
        seg_cnt_next   = seg_cnt_reg;
        ball_px_next   = ball_px_reg;
        ball_py_next   = ball_py_reg;
        ball_vx_next   = ball_vx_reg;
        ball_vy_next   = ball_vy_reg;
        rolling_next   = rolling_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        seg_next       = seg_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        lsq_next       = lsq_reg;
        dot_next       = dot_reg;
        neg_next       = neg_reg;
        qx_next        = qx_reg;
        stat_next      = stat_reg;
        bnc_next       = bnc_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_status_next  = o_status_reg;
        o_px_next      = o_px_reg;
        o_py_next      = o_py_reg;
        o_vx_next      = o_vx_reg;
        o_vy_next      = o_vy_reg;
        o_bnc_next     = o_bnc_reg;
        div_req        = '{1'b0, '0, lsq_reg};
        nmul           = (state_reg == S_REF2) ? ny_reg : nx_reg;
        prod           = 34'(dot_reg * nmul);
        num            = {prod, 1'b0};
        sx  = '0;
        sy  = '0;
        vx2 = '0;
        vy2 = '0;
        m   = '0;
        b78 = '0;
        f   = '0;
        cdx = '0;
        cdy = '0;
        dsq = '0;
        spd = '0;
        qy  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stat_next  = ST_IDLE;
                    bnc_next   = 1'b0;
                    state_next = S_FINISH;
                    if (req_t'(req_type) == REQ_PLACE)
                    begin
                        ball_px_next = (start_x > 12'(POS_MAX_X)) ? 12'(POS_MAX_X) : start_x;
                        ball_py_next = (start_y > 12'(POS_MAX_Y)) ? 12'(POS_MAX_Y) : start_y;
                        ball_vx_next = start_vx;
                        ball_vy_next = start_vy;
                        rolling_next = 1'b1;
                    end
                    else if ((req_t'(req_type) == REQ_TICK) && rolling_reg)
                    begin
                        ax_next = 10'(ball_px_reg[11:FRAC_SHIFT]);
                        ay_next = 10'(ball_py_reg[11:FRAC_SHIFT]);
                        bx_next = to_pix($signed({2'b00, ball_px_reg}) + 14'(ball_vx_reg));
                        by_next = to_pix($signed({2'b00, ball_py_reg}) + 14'(ball_vy_reg));
                        seg_cnt_next = '0;
                        state_next   = S_SEG_ISSUE;
                    end
                end
            end
            S_SEG_ISSUE:
            begin
                state_next = S_SEG_LOAD;
            end
            S_SEG_LOAD:
            begin
                seg_next   = (seg_cnt_reg < SEG_CW'(NUM_BORDERS))
                           ? border_seg(seg_cnt_reg[1:0]) : seg_t'(ram_rdata);
                state_next = S_X1;
            end
            S_X1:
            begin
                state_next = S_X2;
            end
            S_X2:
            begin
                state_next = S_X3;
            end
            S_X3:
            begin
                if (hit)
                begin
                    bnc_next   = 1'b1;
                    state_next = S_REF0;
                end
                else if (seg_cnt_reg + 1'b1 == seg_total)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    seg_cnt_next = seg_cnt_reg + 1'b1;
                    state_next   = S_SEG_ISSUE;
                end
            end
            S_REF0:
            begin
                nx_next  = 11'(seg_reg.y1) - 11'(seg_reg.y2);
                ny_next  = 11'(seg_reg.x2) - 11'(seg_reg.x1);
                lsq_next = 20'(22'(nx_next * nx_next) + 22'(ny_next * ny_next));
                dot_next = 23'(22'(ball_vx_reg * nx_next)) + 23'(22'(ball_vy_reg * ny_next));
                state_next = S_REF1;
            end
            S_REF1:
            begin
                // A zero-length wall cannot hit (zero denominator); if it did, it would leave the velocity.
                if (lsq_reg == '0)
                begin
                    state_next = S_MOVE;
                end
                else
                begin
                    neg_next         = num[34];
                    div_req.start    = 1'b1;
                    div_req.dividend = num[34] ? DIV_W'(-num) : DIV_W'(num);
                    state_next       = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (!div_busy)
                begin
                    qx_next    = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                    state_next = S_REF2;
                end
            end
            S_REF2:
            begin
                neg_next         = num[34];
                div_req.start    = 1'b1;
                div_req.dividend = num[34] ? DIV_W'(-num) : DIV_W'(num);
                state_next       = S_DIVY;
            end
            S_DIVY:
            begin
                if (!div_busy)
                begin
                    state_next = S_REF3;
                end
            end
            S_REF3:
            begin
                qy = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
                ball_vx_next = scale78_sat(34'(ball_vx_reg) - 34'(qx_reg));
                ball_vy_next = scale78_sat(34'(ball_vy_reg) - 34'(qy));
                state_next   = S_MOVE;
            end
            S_MOVE:
            begin
                sx  = $signed({2'b00, ball_px_reg}) + 14'(ball_vx_reg);
                m   = mag11(12'(ball_vx_reg));
                b78 = (14'(m) * 14'd7) >> 3;
                vx2 = 12'(ball_vx_reg);
                ball_px_next = sx[11:0];
                if (sx < 14'(POS_LO))
                begin
                    ball_px_next = 12'(POS_LO);
                    vx2 = $signed(b78[11:0]);
                end
                else if (sx > 14'(POS_HI_X))
                begin
                    ball_px_next = 12'(POS_HI_X);
                    vx2 = -$signed(b78[11:0]);
                end
                f = (15'(mag11(vx2)) * 15'd15) >> 4;
                ball_vx_next = vx2[11] ? -$signed(f[10:0]) : $signed(f[10:0]);

                sy  = $signed({2'b00, ball_py_reg}) + 14'(ball_vy_reg);
                m   = mag11(12'(ball_vy_reg));
                b78 = (14'(m) * 14'd7) >> 3;
                vy2 = 12'(ball_vy_reg);
                ball_py_next = sy[11:0];
                if (sy < 14'(POS_LO))
                begin
                    ball_py_next = 12'(POS_LO);
                    vy2 = $signed(b78[11:0]);
                end
                else if (sy > 14'(POS_HI_Y))
                begin
                    ball_py_next = 12'(POS_HI_Y);
                    vy2 = -$signed(b78[11:0]);
                end
                f = (15'(mag11(vy2)) * 15'd15) >> 4;
                ball_vy_next = vy2[11] ? -$signed(f[10:0]) : $signed(f[10:0]);
                state_next = S_CUP;
            end
            S_CUP:
            begin
                cdx = $signed({2'b00, ball_px_reg[11:FRAC_SHIFT]}) - $signed({2'b00, cup_x_reg});
                cdy = $signed({2'b00, ball_py_reg[11:FRAC_SHIFT]}) - $signed({2'b00, cup_y_reg});
                dsq = 21'(20'(cdx * cdx)) + 21'(20'(cdy * cdy));
                spd = 12'(mag11(12'(ball_vx_reg))) + 12'(mag11(12'(ball_vy_reg)));
                stat_next = ST_ROLL;
                if (dsq <= 21'(cup_r_reg * cup_r_reg))
                begin
                    rolling_next = 1'b0;
                    stat_next    = ST_CUP;
                end
                else if (spd < 12'(stop_thr_reg))
                begin
                    ball_vx_next = '0;
                    ball_vy_next = '0;
                    rolling_next = 1'b0;
                    stat_next    = ST_STOP;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_status_next  = stat_reg;
                    o_px_next      = ball_px_reg;
                    o_py_next      = ball_py_reg;
                    o_vx_next      = ball_vx_reg;
                    o_vy_next      = ball_vy_reg;
                    o_bnc_next     = bnc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = o_status_reg;
    assign pos_x     = o_px_reg;
    assign pos_y     = o_py_reg;
    assign vel_x     = o_vx_reg;
    assign vel_y     = o_vy_reg;
    assign bounced   = o_bnc_reg;

    // The divider is only started when it has finished its previous job.
    assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_busy)
        else $error("divider started while busy");

    // Wall reads only address entries within the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEG_LOAD && seg_cnt_reg >= SEG_CW'(NUM_BORDERS))
        |-> ($past(ram_raddr) < WALL_SLOTS))
        else $error("wall read beyond table");

    // After the move the ball lies inside the clamped field.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CUP) |-> (ball_px_reg >= 12'(POS_LO) && ball_px_reg <= 12'(POS_HI_X)
                                  && ball_py_reg >= 12'(POS_LO) && ball_py_reg <= 12'(POS_HI_Y)))
        else $error("ball outside field after move");

    // A stopped result always reports zero velocity.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && o_status_reg == ST_STOP) |-> (o_vx_reg == '0 && o_vy_reg == '0))
        else $error("stopped ball with velocity");

endmodule
